// File: rtl/middle_insert_queue_top_macros.svh
// Assertion macros used by the queue checker
`ifndef MIDDLE_INSERT_QUEUE_TOP_MACROS_SVH
`define MIDDLE_INSERT_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MIQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue check failed");

// Next-cycle implication, disabled while reset is asserted
`define MIQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

// File: rtl/miq_pkg.sv
// Shared constants, types and helpers for the middle-insert queue
package miq_pkg;

  localparam int HALF_DEPTH = 512;
  localparam int ID_WIDTH   = 16;
  localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HALF_DEPTH + 1);

  // Opcodes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_PRIO = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [ID_WIDTH-1:0] item_id;
  } miq_in_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0] leaving_id;
    logic [1:0]          status;
  } miq_out_t;

  // One ring RAM port bundle: one write and one read per cycle
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ID_WIDTH-1:0] wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } miq_ram_req_t;

  // Ring index add; the offset is at most HALF_DEPTH, so the sum stays below
  // 2*HALF_DEPTH and one subtract wraps
  function automatic logic [ADDR_W-1:0] miq_wrap_add(input logic [ADDR_W-1:0] base,
                                                      input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(HALF_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(HALF_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Ring index step back by one
  function automatic logic [ADDR_W-1:0] miq_wrap_dec(input logic [ADDR_W-1:0] base);
    logic [ADDR_W-1:0] res;
    if (base == '0) begin
      res = ADDR_W'(HALF_DEPTH - 1);
    end else begin
      res = base - ADDR_W'(1);
    end
    return res;
  endfunction

endpackage

// File: rtl/middle_insert_queue_top.sv
// Middle-insert queue: top level joining the sequencer and the two ring RAMs
//
// The queue is split into a front FIFO and a back double-ended ring, each kept
// in its own single-port-write synchronous RAM of HALF_DEPTH entries. On the
// transfer cycle both ring heads are read, and in the following cycle the
// sequencer writes back at most one entry per ring, updates the head and count
// registers and registers the result. busy is high for that one cycle, so no
// new command is taken meanwhile. The result strobe result_valid_o is high
// for exactly one cycle, set from the execute state through the result
// register, and the receiver cannot stall it. The queue holds up to
// 2*HALF_DEPTH-1 identifiers; a push when full is dropped with a full status,
// and a pop when empty returns an empty status and a zero id.
module middle_insert_queue_top
  import miq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  miq_in_t  in_i,
  output logic     result_valid_o,
  output miq_out_t result_o
);

  miq_ram_req_t        front_req;
  miq_ram_req_t        back_req;
  logic [ID_WIDTH-1:0] front_rdata;
  logic [ID_WIDTH-1:0] back_rdata;

  miq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .front_req_o    (front_req),
    .back_req_o     (back_req),
    .front_rdata_i  (front_rdata),
    .back_rdata_i   (back_rdata),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  miq_ring u_front_ring (
    .clk_i   (clk_i),
    .req_i   (front_req),
    .rdata_o (front_rdata)
  );

  miq_ring u_back_ring (
    .clk_i   (clk_i),
    .req_i   (back_req),
    .rdata_o (back_rdata)
  );

endmodule

// File: rtl/miq_ring.sv
// Synchronous ring RAM: one write port, one registered read port
module miq_ring
  import miq_pkg::*;
(
  input  logic                clk_i,
  input  miq_ram_req_t        req_i,
  output logic [ID_WIDTH-1:0] rdata_o
);

  logic [ID_WIDTH-1:0] ring_q [HALF_DEPTH];
  logic [ID_WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      ring_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= ring_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/miq_ctrl.sv
// Queue sequencer: head/count registers, ring accesses and result register
module miq_ctrl
  import miq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  miq_in_t             in_i,
  output miq_ram_req_t        front_req_o,
  output miq_ram_req_t        back_req_o,
  input  logic [ID_WIDTH-1:0] front_rdata_i,
  input  logic [ID_WIDTH-1:0] back_rdata_i,
  output logic                result_valid_o,
  output miq_out_t            result_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } miq_state_e;

  miq_state_e          state_q, state_d;
  logic [1:0]          op_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [ADDR_W-1:0]   front_head_q, front_head_d;
  logic [CNT_W-1:0]    front_count_q, front_count_d;
  logic [ADDR_W-1:0]   back_head_q, back_head_d;
  logic [CNT_W-1:0]    back_count_q, back_count_d;
  logic                result_valid_q, result_valid_d;
  miq_out_t            result_q, result_d;

  logic                accept;
  logic                full;
  logic                empty;
  logic                halves_even;
  logic [ADDR_W-1:0]   front_tail;
  logic [ADDR_W-1:0]   back_tail;
  logic [ADDR_W-1:0]   back_head_dec;

  assign accept        = start && (state_q == S_IDLE);
  assign busy          = (state_q != S_IDLE);
  assign full          = (front_count_q == CNT_W'(HALF_DEPTH));
  assign empty         = (front_count_q == '0);
  assign halves_even   = (front_count_q == back_count_q);
  assign front_tail    = miq_wrap_add(front_head_q, front_count_q);
  assign back_tail     = miq_wrap_add(back_head_q, back_count_q);
  assign back_head_dec = miq_wrap_dec(back_head_q);

  // Read both heads on the transfer; modify and write back in the next cycle
  always_comb begin
    state_d        = state_q;
    front_head_d   = front_head_q;
    front_count_d  = front_count_q;
    back_head_d    = back_head_q;
    back_count_d   = back_count_q;
    result_valid_d = 1'b0;
    result_d       = result_q;

    front_req_o       = '0;
    back_req_o        = '0;
    front_req_o.re    = accept;
    front_req_o.raddr = front_head_q;
    back_req_o.re     = accept;
    back_req_o.raddr  = back_head_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d             = S_IDLE;
        result_valid_d      = 1'b1;
        result_d.leaving_id = '0;
        result_d.status     = ST_OK;
        priority if (op_q == OP_PUSH) begin
          if (full) begin
            result_d.status = ST_FULL;
          end else if (halves_even) begin
            // Append then move the back head forward; an empty back half forwards the id
            front_req_o.we    = 1'b1;
            front_req_o.waddr = front_tail;
            front_req_o.wdata = (back_count_q == '0) ? id_q : back_rdata_i;
            front_count_d     = front_count_q + CNT_W'(1);
            back_head_d       = miq_wrap_add(back_head_q, CNT_W'(1));
            if (back_count_q != '0) begin
              back_req_o.we    = 1'b1;
              back_req_o.waddr = back_tail;
              back_req_o.wdata = id_q;
            end
          end else begin
            back_req_o.we    = 1'b1;
            back_req_o.waddr = back_tail;
            back_req_o.wdata = id_q;
            back_count_d     = back_count_q + CNT_W'(1);
          end
        end else if (op_q == OP_PRIO) begin
          if (full) begin
            result_d.status = ST_FULL;
          end else if (front_count_q <= back_count_q) begin
            front_req_o.we    = 1'b1;
            front_req_o.waddr = front_tail;
            front_req_o.wdata = id_q;
            front_count_d     = front_count_q + CNT_W'(1);
          end else begin
            back_req_o.we    = 1'b1;
            back_req_o.waddr = back_head_dec;
            back_req_o.wdata = id_q;
            back_head_d      = back_head_dec;
            back_count_d     = back_count_q + CNT_W'(1);
          end
        end else if (op_q == OP_POP) begin
          if (empty) begin
            result_d.status = ST_EMPTY;
          end else begin
            result_d.leaving_id = front_rdata_i;
            front_head_d        = miq_wrap_add(front_head_q, CNT_W'(1));
            if (halves_even) begin
              // Refill the front tail from the back head
              front_req_o.we    = 1'b1;
              front_req_o.waddr = front_tail;
              front_req_o.wdata = back_rdata_i;
              back_head_d       = miq_wrap_add(back_head_q, CNT_W'(1));
              back_count_d      = back_count_q - CNT_W'(1);
            end else begin
              front_count_d = front_count_q - CNT_W'(1);
            end
          end
        end else begin
          result_d.status = ST_OK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      front_head_q   <= '0;
      front_count_q  <= '0;
      back_head_q    <= '0;
      back_count_q   <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      front_head_q   <= front_head_d;
      front_count_q  <= front_count_d;
      back_head_q    <= back_head_d;
      back_count_q   <= back_count_d;
      result_valid_q <= result_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_i.opcode;
      id_q <= in_i.item_id;
    end
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// File: rtl/miq_checker.sv
// Port-level checks for the middle-insert queue, bound to the top level
`include "middle_insert_queue_top_macros.svh"

module miq_checker
  import miq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     result_valid_o,
  input miq_out_t result_o
);

  logic xfer;
  assign xfer = start && !busy;

  // A transfer makes the block busy in the cycle after it
  `MIQ_ASSERT_NXT(a_busy_after_xfer, clk_i, rst_ni, xfer, busy)
  // Every result answers an earlier transfer
  `MIQ_ASSERT_IMP(a_result_from_xfer, clk_i, rst_ni, result_valid_o, $past(xfer, 2))
  // A result is shown while the block is ready again
  `MIQ_ASSERT_IMP(a_result_when_free, clk_i, rst_ni, result_valid_o, !busy)
  // Failed commands return no identifier
  `MIQ_ASSERT_IMP(a_fail_zero_id, clk_i, rst_ni,
    result_valid_o && (result_o.status != ST_OK), result_o.leaving_id == '0)

endmodule

bind middle_insert_queue_top miq_checker u_miq_checker (.*);
